[rtl/core/pdf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_pkg
// Shared types and constants of the pixel downscale and flatten block.
// ----------------------------------------------------------------------------
package pdf_pkg;

    localparam int SRC_DIM_MAX = 4096;
    localparam int DST_DIM_MAX = 512;
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);

    localparam int SDIM_W  = 13;   // source dimension register
    localparam int DDIM_W  = 10;   // output dimension register
    localparam int SCNT_W  = 12;   // source column / row counter
    localparam int OCNT_W  = 10;   // output column / row counter
    localparam int PROD_W  = 22;   // target products and low bounds
    localparam int POS_W   = 9;    // output position field
    localparam int WORD_W  = 32;
    localparam int CH_W    = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CH_W-1:0] BG_RED   = 8'd5;
    localparam logic [CH_W-1:0] BG_GREEN = 8'd14;
    localparam logic [CH_W-1:0] BG_BLUE  = 8'd27;
    localparam logic [CH_W-1:0] OPAQUE   = 8'hff;
    localparam logic [WORD_W-1:0] BLACK_ARGB = 32'hff00_0000;

    typedef enum logic [1:0] {
        FMT_PAL8 = 2'd0,
        FMT_RGBA = 2'd1,
        FMT_BGRA = 2'd2,
        FMT_NONE = 2'd3
    } t_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT   = 3'd0,
        CFG_HAS_PAL  = 3'd1,
        CFG_SRC_W    = 3'd2,
        CFG_SRC_H    = 3'd3,
        CFG_DST_W    = 3'd4,
        CFG_DST_H    = 3'd5
    } t_cfg_idx;

    localparam logic CMD_PAL_WRITE = 1'b0;
    localparam logic CMD_PIXEL     = 1'b1;

    // Effective (clamped) frame dimensions
    typedef struct packed {
        logic [SDIM_W-1:0] sw;
        logic [SDIM_W-1:0] sh;
        logic [DDIM_W-1:0] dw;
        logic [DDIM_W-1:0] dh;
    } t_dims;

    // Item handed from the scan counters to the input stage
    typedef struct packed {
        logic              keep;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic              last;
    } t_scan_item;

endpackage

`default_nettype wire

[rtl/core/pixel_downscale_flatten.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_downscale_flatten
// Nearest-neighbour downscaler with palette / RGBA / BGRA decode and alpha
// flattening onto a fixed background.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order on the slave stream, one word per
// clock; palette writes share that stream (tuser low). Each kept pixel comes
// out as opaque RGB with its output position, through the input stage and
// the result register, and tlast marks the bottom-right output pixel.
// Sustained rate is one word per clock while the master side is ready: the
// scan counters advance by adds only, and the palette read is registered.
// Dimension writes restart the frame; write configuration only while idle.
// Out-of-range sizes are clamped (source 1..4096, output 1..512 and not
// above the source). Palette entries never written read as undefined.
// ----------------------------------------------------------------------------
module pixel_downscale_flatten (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [pdf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pdf_pkg::CFG_DATA_W-1:0]   i_cfg_data,

    // source stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [39:0]                      s_axis_tdata,  // pal_index[7:0], pixel_word[39:8]
    input  wire logic                             s_axis_tuser,  // cmd

    // result stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [47:0]                           m_axis_tdata,  // red, green, blue, out_x, out_y, pad
    output logic                                  m_axis_tlast   // last
);

    // ---- configuration registers -------------------------------------------
    pdf_pkg::t_fmt                r_fmt, n_fmt;
    logic                         r_has_pal, n_has_pal;
    logic [pdf_pkg::SDIM_W-1:0]   r_src_w, n_src_w, r_src_h, n_src_h;
    logic [pdf_pkg::DDIM_W-1:0]   r_dst_w, n_dst_w, r_dst_h, n_dst_h;
    pdf_pkg::t_dims               r_dims, n_dims;   // clamped copy
    logic                         dim_write;

    assign o_cfg_ready = 1'b1;

    function automatic logic [pdf_pkg::SDIM_W-1:0] clamp_src(
        input logic [pdf_pkg::SDIM_W-1:0] v
    );
        if (v == '0) return pdf_pkg::SDIM_W'(1);
        if (v > pdf_pkg::SDIM_W'(pdf_pkg::SRC_DIM_MAX))
            return pdf_pkg::SDIM_W'(pdf_pkg::SRC_DIM_MAX);
        return v;
    endfunction

    function automatic logic [pdf_pkg::DDIM_W-1:0] clamp_dst(
        input logic [pdf_pkg::DDIM_W-1:0] v,
        input logic [pdf_pkg::SDIM_W-1:0] src
    );
        logic [pdf_pkg::DDIM_W-1:0] d;
        d = v;
        if (v == '0) d = pdf_pkg::DDIM_W'(1);
        else if (v > pdf_pkg::DDIM_W'(pdf_pkg::DST_DIM_MAX))
            d = pdf_pkg::DDIM_W'(pdf_pkg::DST_DIM_MAX);
        if (pdf_pkg::SDIM_W'(d) > src) d = src[pdf_pkg::DDIM_W-1:0];
        return d;
    endfunction

    always_comb begin
        n_fmt     = r_fmt;
        n_has_pal = r_has_pal;
        n_src_w   = r_src_w;
        n_src_h   = r_src_h;
        n_dst_w   = r_dst_w;
        n_dst_h   = r_dst_h;
        dim_write = 1'b0;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pdf_pkg::CFG_FORMAT:  n_fmt     = pdf_pkg::t_fmt'(i_cfg_data[1:0]);
                pdf_pkg::CFG_HAS_PAL: n_has_pal = i_cfg_data[0];
                pdf_pkg::CFG_SRC_W: begin
                    n_src_w   = i_cfg_data;
                    dim_write = 1'b1;
                end
                pdf_pkg::CFG_SRC_H: begin
                    n_src_h   = i_cfg_data;
                    dim_write = 1'b1;
                end
                pdf_pkg::CFG_DST_W: begin
                    n_dst_w   = i_cfg_data[pdf_pkg::DDIM_W-1:0];
                    dim_write = 1'b1;
                end
                pdf_pkg::CFG_DST_H: begin
                    n_dst_h   = i_cfg_data[pdf_pkg::DDIM_W-1:0];
                    dim_write = 1'b1;
                end
                default: ;   // unused indexes are ignored
            endcase
        end
        n_dims.sw = clamp_src(n_src_w);
        n_dims.sh = clamp_src(n_src_h);
        n_dims.dw = clamp_dst(n_dst_w, n_dims.sw);
        n_dims.dh = clamp_dst(n_dst_h, n_dims.sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= pdf_pkg::FMT_PAL8;
            r_has_pal <= 1'b0;
            r_src_w   <= pdf_pkg::SDIM_W'(1);
            r_src_h   <= pdf_pkg::SDIM_W'(1);
            r_dst_w   <= pdf_pkg::DDIM_W'(1);
            r_dst_h   <= pdf_pkg::DDIM_W'(1);
            r_dims    <= '{sw: pdf_pkg::SDIM_W'(1), sh: pdf_pkg::SDIM_W'(1),
                           dw: pdf_pkg::DDIM_W'(1), dh: pdf_pkg::DDIM_W'(1)};
        end else begin
            r_fmt     <= n_fmt;
            r_has_pal <= n_has_pal;
            r_src_w   <= n_src_w;
            r_src_h   <= n_src_h;
            r_dst_w   <= n_dst_w;
            r_dst_h   <= n_dst_h;
            r_dims    <= n_dims;
        end
    end

    // ---- handshake ---------------------------------------------------------
    // Input stage may take a word when it is empty or draining into the
    // result register this cycle.
    logic out_free, s1_free, s_acc, pix_acc, pal_acc;
    logic r_s1_valid, r_out_valid;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_free       = !r_s1_valid || out_free;
    assign s_axis_tready = s1_free;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign pix_acc       = s_acc && (s_axis_tuser == pdf_pkg::CMD_PIXEL);
    assign pal_acc       = s_acc && (s_axis_tuser == pdf_pkg::CMD_PAL_WRITE);

    // ---- scan counters -----------------------------------------------------
    pdf_pkg::t_scan_item scan_item;

    pdf_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (pix_acc),
        .i_restart (dim_write),
        .i_dims    (r_dims),
        .o_item    (scan_item)
    );

    // ---- palette -----------------------------------------------------------
    // Read is issued at accept, so the entry lines up with the input stage.
    logic [pdf_pkg::WORD_W-1:0] pal_rdata;

    pdf_ram #(
        .WIDTH (pdf_pkg::WORD_W),
        .DEPTH (pdf_pkg::PAL_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_acc),
        .i_waddr (s_axis_tdata[pdf_pkg::PAL_AW-1:0]),
        .i_wdata (s_axis_tdata[39:8]),
        .i_re    (pix_acc),
        .i_raddr (s_axis_tdata[8 +: pdf_pkg::PAL_AW]),
        .o_rdata (pal_rdata)
    );

    // ---- input stage -------------------------------------------------------
    pdf_pkg::t_scan_item          r_s1;
    logic [pdf_pkg::WORD_W-1:0]   r_s1_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= pix_acc && scan_item.keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1      <= scan_item;
            r_s1_word <= s_axis_tdata[39:8];
        end
    end

    // ---- decode and flatten ------------------------------------------------
    logic [pdf_pkg::CH_W-1:0] fl_red, fl_green, fl_blue;

    pdf_flatten u_flatten (
        .i_fmt      (r_fmt),
        .i_has_pal  (r_has_pal),
        .i_word     (r_s1_word),
        .i_pal_word (pal_rdata),
        .o_red      (fl_red),
        .o_green    (fl_green),
        .o_blue     (fl_blue)
    );

    // ---- result register ---------------------------------------------------
    logic [47:0] r_out_data;
    logic        r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_data <= {6'd0, r_s1.y, r_s1.x, fl_blue, fl_green, fl_red};
            r_out_last <= r_s1.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    // a stalled input stage keeps its word
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |=> r_s1_valid && $stable(r_s1))
        else $error("input stage lost or changed a stalled word");

    // palette writes never produce a result
    a_pal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pal_acc |=> !r_s1_valid)
        else $error("palette write entered the pixel path");

    // an input-stage word moves to the result register when it is free
    a_s1_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && out_free |=> r_out_valid)
        else $error("kept pixel dropped between stages");

    // nothing new is taken while both stages are full and stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken with both stages full");
`endif

endmodule

`default_nettype wire

[rtl/core/pdf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pdf_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/pdf_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_scan
// Raster position counters and nearest-neighbour selection. Products are
// kept incrementally, so each pixel needs only adds and compares.
// ----------------------------------------------------------------------------
module pdf_scan (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,     // source pixel accepted
    input  wire logic                i_restart,  // dimension write
    input  wire pdf_pkg::t_dims      i_dims,
    output pdf_pkg::t_scan_item      o_item
);

    logic [pdf_pkg::SCNT_W-1:0] r_scol, n_scol;
    logic [pdf_pkg::SCNT_W-1:0] r_srow, n_srow;
    logic [pdf_pkg::OCNT_W-1:0] r_ocol, n_ocol;
    logic [pdf_pkg::OCNT_W-1:0] r_orow, n_orow;
    logic [pdf_pkg::PROD_W-1:0] r_ctp, n_ctp;    // output column * sw
    logic [pdf_pkg::PROD_W-1:0] r_rtp, n_rtp;    // output row * sh
    logic [pdf_pkg::PROD_W-1:0] r_clo, n_clo;    // source column * dw
    logic [pdf_pkg::PROD_W-1:0] r_rlo, n_rlo;    // source row * dh

    logic [pdf_pkg::PROD_W:0]   col_hi, row_hi;
    logic                       col_hit, row_hit, end_row, end_frame;
    logic [pdf_pkg::SDIM_W-1:0] scol_inc, srow_inc;

    always_comb begin
        col_hi = {1'b0, r_clo} + (pdf_pkg::PROD_W+1)'(i_dims.dw);
        row_hi = {1'b0, r_rlo} + (pdf_pkg::PROD_W+1)'(i_dims.dh);
        col_hit = (r_ocol < i_dims.dw) && (r_ctp >= r_clo)
                  && ({1'b0, r_ctp} < col_hi);
        row_hit = (r_orow < i_dims.dh) && (r_rtp >= r_rlo)
                  && ({1'b0, r_rtp} < row_hi);
        scol_inc  = {1'b0, r_scol} + 1'b1;
        srow_inc  = {1'b0, r_srow} + 1'b1;
        end_row   = scol_inc >= i_dims.sw;
        end_frame = end_row && (srow_inc >= i_dims.sh);

        o_item.keep = col_hit && row_hit;
        o_item.x    = r_ocol[pdf_pkg::POS_W-1:0];
        o_item.y    = r_orow[pdf_pkg::POS_W-1:0];
        o_item.last = (r_ocol == i_dims.dw - 1'b1) && (r_orow == i_dims.dh - 1'b1);

        n_scol = r_scol;
        n_srow = r_srow;
        n_ocol = r_ocol;
        n_orow = r_orow;
        n_ctp  = r_ctp;
        n_rtp  = r_rtp;
        n_clo  = r_clo;
        n_rlo  = r_rlo;
        priority if (i_restart || (i_step && end_frame)) begin
            n_scol = '0;
            n_srow = '0;
            n_ocol = '0;
            n_orow = '0;
            n_ctp  = '0;
            n_rtp  = '0;
            n_clo  = '0;
            n_rlo  = '0;
        end else if (i_step && end_row) begin
            n_scol = '0;
            n_ocol = '0;
            n_ctp  = '0;
            n_clo  = '0;
            n_srow = srow_inc[pdf_pkg::SCNT_W-1:0];
            n_rlo  = r_rlo + pdf_pkg::PROD_W'(i_dims.dh);
            if (row_hit) begin
                n_orow = r_orow + 1'b1;
                n_rtp  = r_rtp + pdf_pkg::PROD_W'(i_dims.sh);
            end
        end else if (i_step) begin
            n_scol = scol_inc[pdf_pkg::SCNT_W-1:0];
            n_clo  = r_clo + pdf_pkg::PROD_W'(i_dims.dw);
            if (col_hit) begin
                n_ocol = r_ocol + 1'b1;
                n_ctp  = r_ctp + pdf_pkg::PROD_W'(i_dims.sw);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scol <= '0;
            r_srow <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_ctp  <= '0;
            r_rtp  <= '0;
            r_clo  <= '0;
            r_rlo  <= '0;
        end else begin
            r_scol <= n_scol;
            r_srow <= n_srow;
            r_ocol <= n_ocol;
            r_orow <= n_orow;
            r_ctp  <= n_ctp;
            r_rtp  <= n_rtp;
            r_clo  <= n_clo;
            r_rlo  <= n_rlo;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pdf_flatten.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_flatten
// Pixel decode by format and alpha blend onto the fixed background colour.
// ----------------------------------------------------------------------------
module pdf_flatten (
    input  wire pdf_pkg::t_fmt                 i_fmt,
    input  wire logic                          i_has_pal,
    input  wire logic [pdf_pkg::WORD_W-1:0]    i_word,
    input  wire logic [pdf_pkg::WORD_W-1:0]    i_pal_word,
    output logic      [pdf_pkg::CH_W-1:0]      o_red,
    output logic      [pdf_pkg::CH_W-1:0]      o_green,
    output logic      [pdf_pkg::CH_W-1:0]      o_blue
);

    // floor((c*a + bg*(255-a)) / 255); sum stays below 2^16, so the
    // divide is (x + 1 + x/256) / 256
    function automatic logic [pdf_pkg::CH_W-1:0] blend(
        input logic [pdf_pkg::CH_W-1:0] c,
        input logic [pdf_pkg::CH_W-1:0] a,
        input logic [pdf_pkg::CH_W-1:0] bg
    );
        logic [15:0] fg_p, bg_p;
        logic [16:0] sum, q;
        fg_p = c * a;
        bg_p = bg * (pdf_pkg::OPAQUE - a);
        sum  = {1'b0, fg_p} + {1'b0, bg_p};
        q    = sum + 17'd1 + {8'd0, sum[16:8]};
        return q[15:8];
    endfunction

    logic [pdf_pkg::WORD_W-1:0] argb;   // a in 31:24, r 23:16, g 15:8, b 7:0

    always_comb begin
        unique case (i_fmt)
            pdf_pkg::FMT_PAL8: argb = i_has_pal ? i_pal_word : pdf_pkg::BLACK_ARGB;
            pdf_pkg::FMT_RGBA: argb = {i_word[31:24], i_word[7:0], i_word[15:8],
                                       i_word[23:16]};
            pdf_pkg::FMT_BGRA: argb = i_word;
            pdf_pkg::FMT_NONE: argb = pdf_pkg::BLACK_ARGB;
            default:           argb = pdf_pkg::BLACK_ARGB;
        endcase

        if (argb[31:24] == pdf_pkg::OPAQUE) begin
            o_red   = argb[23:16];
            o_green = argb[15:8];
            o_blue  = argb[7:0];
        end else begin
            o_red   = blend(argb[23:16], argb[31:24], pdf_pkg::BG_RED);
            o_green = blend(argb[15:8],  argb[31:24], pdf_pkg::BG_GREEN);
            o_blue  = blend(argb[7:0],   argb[31:24], pdf_pkg::BG_BLUE);
        end
    end

endmodule

`default_nettype wire

[tb/sv/tb_pixel_downscale_flatten.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_downscale_flatten
// Self-checking bench for the nearest-neighbour downscaler. A short table of
// directed words runs first, then random frames under four flow-control patterns;
// every output word is checked against an in-bench scan model or a typed row.
// ----------------------------------------------------------------------------
module tb_pixel_downscale_flatten;
    import pdf_pkg::*;

    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 8;       // pipeline is two deep, leave margin
    localparam int TAIL_CYCLES     = 16;
    localparam int LIMIT_CYCLES    = 200000;
    localparam int N_PHASES        = 12;
    localparam int WORDS_PER_PHASE = 60;
    localparam int PAL_WRITE_PCT   = 15;
    localparam int N_PLAN          = 34;
    localparam int MAX_REPORTS     = 10;

    typedef enum int {
        FLOW_FREE,
        FLOW_SEND_IDLE,
        FLOW_RECV_STALL,
        FLOW_BOTH
    } flow_t;

    // one output word, fields as carried on the master stream
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] out_x;
        logic [8:0] out_y;
        logic       last;
    } out_pixel_t;

    // directed table row: either a register write or a stream word
    typedef struct packed {
        logic       is_reg;
        t_cfg_idx   reg_idx;
        logic [12:0] reg_val;
        logic       cmd;
        logic [7:0] pal_index;
        logic [31:0] word;
        logic       typed;       // want holds a hand-written expectation
        out_pixel_t want;
    } plan_row_t;

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [12:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // pal_index[7:0], pixel_word[39:8]
    logic        s_axis_tuser  = 1'b0; // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // red, green, blue, out_x, out_y, pad
    logic        m_axis_tlast;         // last

    pixel_downscale_flatten uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Scan model: own copy of registers, counters and palette
    // ------------------------------------------------------------------------
    t_fmt        m_fmt;
    logic        m_has_pal;
    int unsigned m_sw_reg, m_sh_reg, m_dw_reg, m_dh_reg;
    int unsigned src_col, src_row, out_col, out_row, col_prod, row_prod;
    logic [31:0] palette [PAL_ENTRIES];
    bit          pal_known [PAL_ENTRIES];
    int unsigned known_idx [$];          // entries safe to look up

    out_pixel_t  kept_pixels_q [$];      // output words still owed by the DUT
    flow_t       flow_mode    = FLOW_FREE;
    int          err_count    = 0;
    int          cycle_count  = 0;
    plan_row_t   plan [N_PLAN];

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // blend one channel onto the background, truncating
    function automatic int unsigned flatten(int unsigned c, int unsigned a,
                                            int unsigned bg);
        return (c * a + bg * (255 - a)) / 255;
    endfunction

    function void restart_scan();
        src_col  = 0;
        src_row  = 0;
        out_col  = 0;
        out_row  = 0;
        col_prod = 0;
        row_prod = 0;
    endfunction

    // register write as the block sees it; size writes restart the frame
    function void mirror_reg_write(t_cfg_idx idx, logic [12:0] val);
        case (idx)
            CFG_FORMAT:  m_fmt = t_fmt'(val[1:0]);
            CFG_HAS_PAL: m_has_pal = val[0];
            CFG_SRC_W: begin
                m_sw_reg = val;
                restart_scan();
            end
            CFG_SRC_H: begin
                m_sh_reg = val;
                restart_scan();
            end
            CFG_DST_W: begin
                m_dw_reg = val[9:0];
                restart_scan();
            end
            CFG_DST_H: begin
                m_dh_reg = val[9:0];
                restart_scan();
            end
            default: ;
        endcase
    endfunction

    // Advance the model by one accepted word; returns 1 when a pixel is kept.
    function bit downscale_step(logic cmd, logic [7:0] idx, logic [31:0] word,
                                output out_pixel_t px);
        int unsigned sw, sh, dw, dh, lo, r, g, b, a;
        logic [31:0] argb;
        bit          col_hit, row_hit, kept;
        px   = '0;
        kept = 1'b0;
        // palette writes touch only the store, never the scan counters
        if (cmd == CMD_PAL_WRITE) begin
            palette[idx] = word;
            if (!pal_known[idx]) begin
                pal_known[idx] = 1'b1;
                known_idx.insert(known_idx.size(), idx);
            end
            return 1'b0;
        end
        sw = clamp_dim(m_sw_reg, SRC_DIM_MAX);
        sh = clamp_dim(m_sh_reg, SRC_DIM_MAX);
        dw = clamp_dim(m_dw_reg, DST_DIM_MAX);
        dh = clamp_dim(m_dh_reg, DST_DIM_MAX);
        if (dw > sw) dw = sw;
        if (dh > sh) dh = sh;
        // kept when out*src lands in [src_pos*dst, src_pos*dst + dst)
        lo      = src_col * dw;
        col_hit = (out_col < dw) && (col_prod >= lo) && (col_prod < lo + dw);
        lo      = src_row * dh;
        row_hit = (out_row < dh) && (row_prod >= lo) && (row_prod < lo + dh);
        if (col_hit && row_hit) begin
            r = 0;
            g = 0;
            b = 0;
            a = 255;
            case (m_fmt)
                FMT_PAL8: begin
                    argb = BLACK_ARGB;
                    if (m_has_pal) argb = palette[word[7:0]];
                    b = argb[7:0];
                    g = argb[15:8];
                    r = argb[23:16];
                    a = argb[31:24];
                end
                FMT_RGBA: begin
                    r = word[7:0];
                    g = word[15:8];
                    b = word[23:16];
                    a = word[31:24];
                end
                FMT_BGRA: begin
                    b = word[7:0];
                    g = word[15:8];
                    r = word[23:16];
                    a = word[31:24];
                end
                default: ;   // unsupported: opaque black
            endcase
            if (a < 255) begin
                r = flatten(r, a, BG_RED);
                g = flatten(g, a, BG_GREEN);
                b = flatten(b, a, BG_BLUE);
            end
            px.red   = 8'(r);
            px.green = 8'(g);
            px.blue  = 8'(b);
            px.out_x = 9'(out_col);
            px.out_y = 9'(out_row);
            px.last  = (out_col == dw - 1) && (out_row == dh - 1);
            kept     = 1'b1;
        end
        if (col_hit) begin
            out_col++;
            col_prod += sw;
        end
        src_col++;
        if (src_col >= sw) begin
            src_col  = 0;
            out_col  = 0;
            col_prod = 0;
            if (row_hit) begin
                out_row++;
                row_prod += sh;
            end
            src_row++;
            if (src_row >= sh) restart_scan();
        end
        return kept;
    endfunction

    // ------------------------------------------------------------------------
    // Table row builders
    // ------------------------------------------------------------------------
    function automatic plan_row_t reg_row(t_cfg_idx idx, logic [12:0] val);
        plan_row_t row;
        row         = '0;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic plan_row_t word_row(logic cmd, logic [7:0] idx, logic [31:0] word);
        plan_row_t row;
        row           = '0;
        row.cmd       = cmd;
        row.pal_index = idx;
        row.word      = word;
        return row;
    endfunction

    // pixel into a 1x1 frame: always kept at (0,0) with last set
    function automatic plan_row_t one_by_one_row(logic [31:0] word, logic [7:0] r,
                                                 logic [7:0] g, logic [7:0] b);
        plan_row_t row;
        row            = word_row(CMD_PIXEL, 8'h00, word);
        row.typed      = 1'b1;
        row.want.red   = r;
        row.want.green = g;
        row.want.blue  = b;
        row.want.last  = 1'b1;
        return row;
    endfunction

    function automatic logic [31:0] rand_argb();
        logic [31:0] w;
        w = $urandom;
        // bias alpha to the opaque and transparent ends
        case ($urandom_range(0, 3))
            0:       w[31:24] = 8'hff;
            1:       w[31:24] = 8'h00;
            default: ;
        endcase
        return w;
    endfunction

    function automatic int unsigned sender_gap_pct();
        case (flow_mode)
            FLOW_SEND_IDLE: return 50;
            FLOW_BOTH:      return 16;
            default:        return 0;
        endcase
    endfunction

    function automatic int unsigned recv_stall_pct();
        case (flow_mode)
            FLOW_RECV_STALL: return 50;
            FLOW_BOTH:       return 16;
            default:         return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers: everything changes on the falling edge
    // ------------------------------------------------------------------------
    // Offer one word; valid stays high on return so the next word can follow
    // straight on. The model is advanced at the accepting edge.
    task automatic push_word(logic cmd, logic [7:0] idx, logic [31:0] word,
                             logic typed, out_pixel_t want);
        out_pixel_t px;
        while ($urandom_range(0, 99) < sender_gap_pct()) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {word, idx};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        if (downscale_step(cmd, idx, word, px)) begin
            if (typed) px = want;
            kept_pixels_q.insert(kept_pixels_q.size(), px);
        end
        @(negedge i_clk);
    endtask

    // Register writes only once the block has drained; palette writes give
    // no output word, so wait out the pipeline as well.
    task automatic write_reg(t_cfg_idx idx, logic [12:0] val);
        s_axis_tvalid = 1'b0;
        while (kept_pixels_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        mirror_reg_write(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // receiver back-pressure
    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct());
    end

    // ------------------------------------------------------------------------
    // Output checker, sampled on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        out_pixel_t got, want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got.red   = m_axis_tdata[7:0];
            got.green = m_axis_tdata[15:8];
            got.blue  = m_axis_tdata[23:16];
            got.out_x = m_axis_tdata[32:24];
            got.out_y = m_axis_tdata[41:33];
            got.last  = m_axis_tlast;
            if (kept_pixels_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected output word r%02h g%02h b%02h x%0d y%0d last%0b",
                             $realtime, got.red, got.green, got.blue,
                             got.out_x, got.out_y, got.last);
            end else begin
                want = kept_pixels_q.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%0t: pixel mismatch", $realtime);
                        $display("  want r%02h g%02h b%02h x%0d y%0d last%0b",
                                 want.red, want.green, want.blue,
                                 want.out_x, want.out_y, want.last);
                        $display("  got  r%02h g%02h b%02h x%0d y%0d last%0b",
                                 got.red, got.green, got.blue,
                                 got.out_x, got.out_y, got.last);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_pixel_downscale_flatten: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int          p, n;
        int unsigned sw, sh;
        logic        cmd;
        logic [7:0]  idx;
        logic [31:0] word;

        // model at reset: indexed format, no palette, 1x1 frame
        m_fmt     = FMT_PAL8;
        m_has_pal = 1'b0;
        m_sw_reg  = 1;
        m_sh_reg  = 1;
        m_dw_reg  = 1;
        m_dh_reg  = 1;
        restart_scan();
        foreach (palette[i]) begin
            palette[i]   = '0;
            pal_known[i] = 1'b0;
        end

        plan = '{
            // reset state: indexed without palette gives opaque black
            one_by_one_row(32'hffff_ffff, 8'h00, 8'h00, 8'h00),
            word_row(CMD_PAL_WRITE, 8'd0,   32'h80ff_8040),   // half alpha
            word_row(CMD_PAL_WRITE, 8'd255, 32'hff12_3456),   // opaque, top entry
            word_row(CMD_PAL_WRITE, 8'd7,   32'h00ff_ffff),   // fully transparent
            reg_row(CFG_HAS_PAL, 13'd1),
            word_row(CMD_PIXEL, 8'h5a, 32'habcd_ef00),
            one_by_one_row(32'h0000_00ff, 8'h12, 8'h34, 8'h56),
            one_by_one_row(32'h0000_0007, BG_RED, BG_GREEN, BG_BLUE),
            reg_row(CFG_FORMAT, FMT_RGBA),
            one_by_one_row(32'hff33_2211, 8'h11, 8'h22, 8'h33),
            one_by_one_row(32'h00ff_ffff, BG_RED, BG_GREEN, BG_BLUE),
            one_by_one_row(32'hffff_ffff, 8'hff, 8'hff, 8'hff),
            word_row(CMD_PIXEL, 8'ha5, 32'h7f80_8080),
            reg_row(CFG_FORMAT, FMT_BGRA),
            one_by_one_row(32'hff33_2211, 8'h33, 8'h22, 8'h11),
            word_row(CMD_PIXEL, 8'hff, 32'h01ff_ffff),
            reg_row(CFG_FORMAT, FMT_NONE),
            one_by_one_row(32'h1234_5678, 8'h00, 8'h00, 8'h00),
            // 3x2 source, output width asked above source, one output row
            reg_row(CFG_FORMAT, FMT_RGBA),
            reg_row(CFG_SRC_W, 13'd3),
            reg_row(CFG_SRC_H, 13'd2),
            reg_row(CFG_DST_W, 13'd5),
            reg_row(CFG_DST_H, 13'd1),
            word_row(CMD_PIXEL, 8'h00, 32'hff00_00ff),
            word_row(CMD_PIXEL, 8'h01, 32'h8010_2030),
            word_row(CMD_PIXEL, 8'h02, 32'hffff_ff00),
            word_row(CMD_PIXEL, 8'h03, 32'h40a0_b0c0),
            word_row(CMD_PIXEL, 8'h04, 32'hff00_ff00),
            word_row(CMD_PIXEL, 8'h05, 32'h0000_0000),
            // zero sizes count as one
            reg_row(CFG_SRC_W, 13'd0),
            reg_row(CFG_SRC_H, 13'd0),
            reg_row(CFG_DST_W, 13'd0),
            reg_row(CFG_DST_H, 13'd0),
            one_by_one_row(32'hff01_0203, 8'h03, 8'h02, 8'h01)
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table, no flow control
        flow_mode = FLOW_FREE;
        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                push_word(plan[i].cmd, plan[i].pal_index, plan[i].word,
                          plan[i].typed, plan[i].want);
            end
        end

        // random frames; flow pattern rotates with the phase
        for (p = 0; p < N_PHASES; p++) begin
            flow_mode = flow_t'(p % 4);
            case (p)
                2: begin          // largest legal sizes
                    sw = SRC_DIM_MAX;
                    sh = SRC_DIM_MAX;
                    write_reg(CFG_DST_W, 13'(DST_DIM_MAX));
                    write_reg(CFG_DST_H, 13'(DST_DIM_MAX));
                end
                5: begin          // all-ones registers, clamped inside
                    sw = 8191;
                    sh = 8191;
                    write_reg(CFG_DST_W, 13'd1023);
                    write_reg(CFG_DST_H, 13'd1023);
                end
                8: begin          // output asked larger than source
                    sw = 5;
                    sh = 3;
                    write_reg(CFG_DST_W, 13'd1023);
                    write_reg(CFG_DST_H, 13'd600);
                end
                default: begin
                    sw = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 16);
                    sh = $urandom_range(0, 8);
                    write_reg(CFG_DST_W, 13'($urandom_range(0, sw + 2)));
                    write_reg(CFG_DST_H, 13'($urandom_range(0, sh + 2)));
                end
            endcase
            write_reg(CFG_SRC_W, 13'(sw));
            write_reg(CFG_SRC_H, 13'(sh));
            write_reg(CFG_FORMAT, 13'($urandom_range(0, 3)));
            write_reg(CFG_HAS_PAL, 13'($urandom_range(0, 1)));

            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                word = rand_argb();
                idx  = $urandom_range(0, 255);
                if ($urandom_range(0, 99) < PAL_WRITE_PCT) begin
                    cmd = CMD_PAL_WRITE;
                end else begin
                    cmd = CMD_PIXEL;
                    // indexed lookups stay on entries already loaded
                    if (m_fmt == FMT_PAL8 && m_has_pal)
                        word[7:0] = 8'(known_idx[$urandom_range(0, known_idx.size() - 1)]);
                end
                push_word(cmd, idx, word, 1'b0, '0);
            end
        end
        s_axis_tvalid = 1'b0;

        // drain, then let any stray words show up
        while (kept_pixels_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (err_count == 0 && kept_pixels_q.size() == 0) begin
            $display("tb_pixel_downscale_flatten: clean");
        end else begin
            $display("tb_pixel_downscale_flatten: errors");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/pdf_pkg.sv
rtl/core/pdf_ram.sv
rtl/core/pdf_scan.sv
rtl/core/pdf_flatten.sv
rtl/core/pixel_downscale_flatten.sv
tb/sv/tb_pixel_downscale_flatten.sv
